// ===== rtl/vboc_pkg.sv =====
// Shared types, constants and codes for the video buffer occupancy checker.
// Depends on nothing; every other file in rtl/ imports it.
package vboc_pkg;

    // Field and datapath widths
    localparam int STAMP_WIDTH = 33;
    localparam int COUNT_WIDTH = 32;
    localparam int BYTES_W     = 24;
    localparam int LEVEL_W     = 31;
    localparam int RATE_W      = 32;
    localparam int FULL_W      = 15;
    localparam int EV_W        = 3;

    // Configuration register widths
    localparam int SIZE_W = 28;
    localparam int FILL_W = 30;
    localparam int TPS_W  = 20;
    localparam int DGAP_W = 20;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Shared divider widths
    localparam int DIV_W  = 33;
    localparam int DVD_W  = 34;
    localparam int QUO_W  = 34;
    localparam int STEP_W = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_RATE    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_S  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_GAP  = 4'd3;

    localparam logic [SIZE_W-1:0] RST_BUFFER_SIZE = 28'd3125000;
    localparam logic [FILL_W-1:0] RST_FILL_RATE   = 30'd5000000;
    localparam logic [TPS_W-1:0]  RST_TICKS_PER_S = 20'd90000;
    localparam logic [DGAP_W-1:0] RST_DEFAULT_GAP = 20'd3000;

    localparam logic [RATE_W-1:0]  RATE_MIN_RESET  = 32'd1000000000;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN_RESET = '1;

    // Event codes
    localparam logic [EV_W-1:0] EV_NORMAL     = 3'd0;
    localparam logic [EV_W-1:0] EV_NEAR_OVER  = 3'd1;
    localparam logic [EV_W-1:0] EV_OVER       = 3'd2;
    localparam logic [EV_W-1:0] EV_NEAR_UNDER = 3'd3;
    localparam logic [EV_W-1:0] EV_UNDER      = 3'd4;

    typedef struct packed {
        logic [STAMP_WIDTH-1:0] stamp_ticks;
        logic                   stamp_present;
        logic [BYTES_W-1:0]     packet_bytes;
    } in_beat_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]     level_bits;
        logic [FULL_W-1:0]      fullness_q8;
        logic [EV_W-1:0]        event_code;
        logic [RATE_W-1:0]      packet_rate_bps;
        logic [COUNT_WIDTH-1:0] overflow_total;
        logic [COUNT_WIDTH-1:0] underflow_total;
        logic [COUNT_WIDTH-1:0] near_overflow_total;
        logic [COUNT_WIDTH-1:0] near_underflow_total;
        logic [LEVEL_W-1:0]     peak_level_bits;
        logic [LEVEL_W-1:0]     least_level_bits;
        logic [RATE_W-1:0]      peak_rate_bps;
        logic [RATE_W-1:0]      least_rate_bps;
    } out_beat_t;

    // Divider request: remainder seed, dividend bits fed MSB first, divisor
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  rem_init;
        logic [DVD_W-1:0]  dvd;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

    // Event counters and extremes after the current packet
    typedef struct packed {
        logic [EV_W-1:0]        ev;
        logic [COUNT_WIDTH-1:0] overflow_total;
        logic [COUNT_WIDTH-1:0] underflow_total;
        logic [COUNT_WIDTH-1:0] near_overflow_total;
        logic [COUNT_WIDTH-1:0] near_underflow_total;
        logic [LEVEL_W-1:0]     peak_level;
        logic [LEVEL_W-1:0]     least_level;
        logic [RATE_W-1:0]      peak_rate;
        logic [RATE_W-1:0]      least_rate;
    } stats_t;

endpackage

// ===== rtl/vboc_mul.sv =====
// Shared registered multiplier used for the fill product and the rate product.
// Depends on vboc_pkg for operand widths.
module vboc_mul (
    input  logic                         clk,
    input  logic [vboc_pkg::MUL_A_W-1:0] a,
    input  logic [vboc_pkg::MUL_B_W-1:0] b,
    output logic [vboc_pkg::MUL_P_W-1:0] p
);
    import vboc_pkg::*;

    logic [MUL_P_W-1:0] p_reg;

    // Register the product every cycle
    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== rtl/vboc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on vboc_pkg for the request and response structs.
module vboc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  vboc_pkg::div_req_t  req,
    output vboc_pkg::div_rsp_t  rsp
);
    import vboc_pkg::*;

    logic [DIV_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  divisor_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_W:0]    rem_sh;
    logic [DIV_W:0]    rem_diff;
    logic              ge;

    // Shift in the next dividend bit and trial-subtract
    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge       = (rem_sh >= {1'b0, divisor_reg});
    assign rem_diff = rem_sh - {1'b0, divisor_reg};

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == STEP_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Load operands, then advance one bit a cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.rem_init;
            dvd_reg     <= req.dvd;
            divisor_reg <= req.divisor;
            quo_reg     <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== rtl/vboc_stats.sv =====
// Fullness classification, saturating event counters and level/rate extremes.
// Depends on vboc_pkg for event codes and the stats struct.
module vboc_stats (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         update,
    input  logic [vboc_pkg::LEVEL_W-1:0] level,
    input  logic [vboc_pkg::RATE_W-1:0]  rate,
    input  logic [vboc_pkg::LEVEL_W-1:0] cap,
    output vboc_pkg::stats_t             stats
);
    import vboc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] over_reg, under_reg, near_over_reg, near_under_reg;
    logic [COUNT_WIDTH-1:0] over_next, under_next, near_over_next, near_under_next;
    logic [LEVEL_W-1:0]     peak_level_reg, least_level_reg;
    logic [LEVEL_W-1:0]     peak_level_next, least_level_next;
    logic [RATE_W-1:0]      peak_rate_reg, least_rate_reg;
    logic [RATE_W-1:0]      peak_rate_next, least_rate_next;
    logic [LEVEL_W+3:0]     level_x10;
    logic [LEVEL_W+3:0]     cap_x9;
    logic [EV_W-1:0]        ev;

    // Classify fullness against the capacity: empty buffer or zero capacity first, then overflow
    assign level_x10 = ({3'b0, level, 1'b0} + {level, 3'b0});
    assign cap_x9    = ({4'b0, cap} + {cap, 3'b0});

    always_comb
    begin
        priority if ((cap == '0) || (level == '0))
            ev = EV_UNDER;
        else if (level >= cap)
            ev = EV_OVER;
        else if (level_x10 >= cap_x9)
            ev = EV_NEAR_OVER;
        else if (level_x10 <= {4'b0, cap})
            ev = EV_NEAR_UNDER;
        else
            ev = EV_NORMAL;
    end

    // Bump the matching counter, hold at all ones
    always_comb
    begin
        over_next       = over_reg;
        under_next      = under_reg;
        near_over_next  = near_over_reg;
        near_under_next = near_under_reg;
        if ((ev == EV_OVER) && (over_reg != COUNT_MAX))
            over_next = over_reg + COUNT_WIDTH'(1);
        if ((ev == EV_UNDER) && (under_reg != COUNT_MAX))
            under_next = under_reg + COUNT_WIDTH'(1);
        if ((ev == EV_NEAR_OVER) && (near_over_reg != COUNT_MAX))
            near_over_next = near_over_reg + COUNT_WIDTH'(1);
        if ((ev == EV_NEAR_UNDER) && (near_under_reg != COUNT_MAX))
            near_under_next = near_under_reg + COUNT_WIDTH'(1);
    end

    // Track extremes
    assign peak_level_next  = (level > peak_level_reg)  ? level : peak_level_reg;
    assign least_level_next = (level < least_level_reg) ? level : least_level_reg;
    assign peak_rate_next   = (rate > peak_rate_reg)    ? rate  : peak_rate_reg;
    assign least_rate_next  = (rate < least_rate_reg)   ? rate  : least_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            over_reg        <= '0;
            under_reg       <= '0;
            near_over_reg   <= '0;
            near_under_reg  <= '0;
            peak_level_reg  <= '0;
            least_level_reg <= LEVEL_MIN_RESET;
            peak_rate_reg   <= '0;
            least_rate_reg  <= RATE_MIN_RESET;
        end
        else if (update)
        begin
            over_reg        <= over_next;
            under_reg       <= under_next;
            near_over_reg   <= near_over_next;
            near_under_reg  <= near_under_next;
            peak_level_reg  <= peak_level_next;
            least_level_reg <= least_level_next;
            peak_rate_reg   <= peak_rate_next;
            least_rate_reg  <= least_rate_next;
        end
    end

    assign stats.ev                   = ev;
    assign stats.overflow_total       = over_next;
    assign stats.underflow_total      = under_next;
    assign stats.near_overflow_total  = near_over_next;
    assign stats.near_underflow_total = near_under_next;
    assign stats.peak_level           = peak_level_next;
    assign stats.least_level          = least_level_next;
    assign stats.peak_rate            = peak_rate_next;
    assign stats.least_rate           = least_rate_next;

endmodule

// ===== rtl/video_buffer_occupancy_checker.sv =====
// Top level of the leaky-bucket decoder buffer checker: sequencer, state, ports.
// Depends on vboc_pkg, vboc_mul, vboc_div and vboc_stats.
//
// One packet beat in, one result beat out. The time from a packet's acceptance until
// its result is loaded into the output register is set almost entirely by the
// shared one-bit-per-cycle divider, which runs three times per packet: 34 steps for
// the channel fill, 32 for the instantaneous bitrate and 15
// for the fullness. The input is ready only while the sequencer is idle; a
// finished result waits in the output register, and the next packet may be
// accepted while it waits. The configuration port is always ready; write it only
// while no packet is in flight.
module video_buffer_occupancy_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  vboc_pkg::in_beat_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output vboc_pkg::out_beat_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vboc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vboc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vboc_pkg::*;

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_MUL_HI     = 4'd1;
    localparam logic [3:0] ST_MUL_LO     = 4'd2;
    localparam logic [3:0] ST_MUL_RATE   = 4'd3;
    localparam logic [3:0] ST_FILL_START = 4'd4;
    localparam logic [3:0] ST_FILL_WAIT  = 4'd5;
    localparam logic [3:0] ST_LEVEL      = 4'd6;
    localparam logic [3:0] ST_RATE_START = 4'd7;
    localparam logic [3:0] ST_RATE_WAIT  = 4'd8;
    localparam logic [3:0] ST_FULL_START = 4'd9;
    localparam logic [3:0] ST_FULL_WAIT  = 4'd10;
    localparam logic [3:0] ST_STATS      = 4'd11;

    localparam logic [STEP_W-1:0] FILL_STEPS = 6'd34;
    localparam logic [STEP_W-1:0] RATE_STEPS = 6'd32;
    localparam logic [STEP_W-1:0] FULL_STEPS = 6'd15;

    localparam int ACC_W   = FILL_W + STAMP_WIDTH;
    localparam int RPROD_W = BYTES_W + TPS_W + 3;
    localparam int FPROD_W = LEVEL_W + 15;
    localparam int SUM_W   = QUO_W + 1;

    // Configuration registers
    logic [SIZE_W-1:0] size_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [TPS_W-1:0]  tps_reg;
    logic [DGAP_W-1:0] dgap_reg;

    // Sequencer and per-packet state
    logic [3:0]             state_reg, state_next;
    logic [LEVEL_W-1:0]     level_reg;
    logic [STAMP_WIDTH-1:0] prev_stamp_reg;
    logic [STAMP_WIDTH-1:0] gap_reg;
    logic [BYTES_W-1:0]     bytes_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [RPROD_W-1:0]     rprod_reg;
    logic                   fill_sat_reg;
    logic                   rate_sat_reg;
    logic [QUO_W-1:0]       added_reg;
    logic [RATE_W-1:0]      rate_reg;
    logic [FULL_W-1:0]      full_reg;
    logic                   out_valid_reg;
    out_beat_t              out_data_reg;

    logic                   in_fire;
    logic                   out_free;
    logic                   stats_update;
    logic [STAMP_WIDTH-1:0] stamp_eff;
    logic [STAMP_WIDTH-1:0] gap_new;
    logic [TPS_W-1:0]       tps_eff;
    logic [LEVEL_W-1:0]     cap;
    logic [SUM_W-1:0]       sum_w, take_w, drained;
    logic [LEVEL_W-1:0]     level_new;
    logic [FPROD_W-1:0]     full_prod;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [MUL_P_W-1:0]     mul_p;
    div_req_t               div_req;
    div_rsp_t               div_rsp;
    stats_t                 stats;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign stats_update = (state_reg == ST_STATS) && out_free;

    assign tps_eff = (tps_reg == '0) ? TPS_W'(1) : tps_reg;
    assign cap     = {size_reg, 3'b0};

    // Gap since the previous stamp, falling back to the default gap
    assign stamp_eff = in_data.stamp_present ? in_data.stamp_ticks : '0;
    assign gap_new   = ((prev_stamp_reg == '0) || (stamp_eff <= prev_stamp_reg))
                       ? STAMP_WIDTH'(dgap_reg) : (stamp_eff - prev_stamp_reg);

    // Add the fill, drain the packet, clamp to capacity
    assign sum_w     = SUM_W'(level_reg) + SUM_W'(added_reg);
    assign take_w    = SUM_W'({bytes_reg, 3'b0});
    assign drained   = (sum_w <= take_w) ? '0 : (sum_w - take_w);
    assign level_new = (drained > SUM_W'(cap)) ? cap : drained[LEVEL_W-1:0];

    // level * 25600 as three shifted terms
    assign full_prod = (FPROD_W'(level_reg) << 14) + (FPROD_W'(level_reg) << 13)
                     + (FPROD_W'(level_reg) << 10);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= RST_BUFFER_SIZE;
            fill_reg <= RST_FILL_RATE;
            tps_reg  <= RST_TICKS_PER_S;
            dgap_reg <= RST_DEFAULT_GAP;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BUFFER_SIZE: size_reg <= cfg_data[SIZE_W-1:0];
                REG_FILL_RATE:   fill_reg <= cfg_data[FILL_W-1:0];
                REG_TICKS_PER_S: tps_reg  <= cfg_data[TPS_W-1:0];
                REG_DEFAULT_GAP: dgap_reg <= cfg_data[DGAP_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_fire) state_next = ST_MUL_HI;
            ST_MUL_HI:     state_next = ST_MUL_LO;
            ST_MUL_LO:     state_next = ST_MUL_RATE;
            ST_MUL_RATE:   state_next = ST_FILL_START;
            ST_FILL_START: state_next = ST_FILL_WAIT;
            ST_FILL_WAIT:  if (div_rsp.done) state_next = ST_LEVEL;
            ST_LEVEL:      state_next = ST_RATE_START;
            ST_RATE_START: state_next = ST_RATE_WAIT;
            ST_RATE_WAIT:  if (div_rsp.done) state_next = ST_FULL_START;
            ST_FULL_START: state_next = ST_FULL_WAIT;
            ST_FULL_WAIT:  if (div_rsp.done) state_next = ST_STATS;
            ST_STATS:      if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Multiplier operands: fill rate by gap halves, then packet bytes by tick rate
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_HI:
            begin
                mul_a = fill_reg;
                mul_b = MUL_B_W'(gap_reg[STAMP_WIDTH-1:16]);
            end
            ST_MUL_LO:
            begin
                mul_a = fill_reg;
                mul_b = MUL_B_W'(gap_reg[15:0]);
            end
            default:
            begin
                mul_a = MUL_A_W'(tps_eff);
                mul_b = bytes_reg;
            end
        endcase
    end

    // Divider requests
    always_comb
    begin
        div_req = '0;
        unique case (state_reg)
            ST_FILL_START:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = FILL_STEPS;
                div_req.rem_init = DIV_W'(acc_reg[ACC_W-1:DVD_W]);
                div_req.dvd      = acc_reg[DVD_W-1:0];
                div_req.divisor  = DIV_W'(tps_eff);
            end
            ST_RATE_START:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = RATE_STEPS;
                div_req.rem_init = DIV_W'(rprod_reg[RPROD_W-1:32]);
                div_req.dvd      = {rprod_reg[31:0], 2'b0};
                div_req.divisor  = gap_reg;
            end
            ST_FULL_START:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = FULL_STEPS;
                div_req.rem_init = DIV_W'(full_prod[FPROD_W-1:15]);
                div_req.dvd      = {full_prod[14:0], 19'b0};
                div_req.divisor  = DIV_W'(cap);
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            level_reg      <= '0;
            prev_stamp_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
                prev_stamp_reg <= stamp_eff;
            if (state_reg == ST_LEVEL)
                level_reg <= level_new;
            if (stats_update)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            gap_reg   <= gap_new;
            bytes_reg <= in_data.packet_bytes;
        end
        if (state_reg == ST_MUL_LO)
            acc_reg <= {mul_p[FILL_W+16:0], 16'b0};
        if (state_reg == ST_MUL_RATE)
            acc_reg <= acc_reg + ACC_W'(mul_p[FILL_W+15:0]);
        if (state_reg == ST_FILL_START)
        begin
            rprod_reg    <= {mul_p[BYTES_W+TPS_W-1:0], 3'b0};
            fill_sat_reg <= (acc_reg[ACC_W-1:DVD_W] >= (ACC_W - DVD_W)'(tps_eff));
        end
        if ((state_reg == ST_FILL_WAIT) && div_rsp.done)
            added_reg <= fill_sat_reg ? '1 : div_rsp.quo;
        if (state_reg == ST_RATE_START)
            rate_sat_reg <= (gap_reg == '0)
                            || (STAMP_WIDTH'(rprod_reg[RPROD_W-1:32]) >= gap_reg);
        if ((state_reg == ST_RATE_WAIT) && div_rsp.done)
            rate_reg <= rate_sat_reg ? '1 : div_rsp.quo[RATE_W-1:0];
        if ((state_reg == ST_FULL_WAIT) && div_rsp.done)
            full_reg <= (cap == '0) ? '0 : div_rsp.quo[FULL_W-1:0];
        if (stats_update)
        begin
            out_data_reg.level_bits           <= level_reg;
            out_data_reg.fullness_q8          <= full_reg;
            out_data_reg.event_code           <= stats.ev;
            out_data_reg.packet_rate_bps      <= rate_reg;
            out_data_reg.overflow_total       <= stats.overflow_total;
            out_data_reg.underflow_total      <= stats.underflow_total;
            out_data_reg.near_overflow_total  <= stats.near_overflow_total;
            out_data_reg.near_underflow_total <= stats.near_underflow_total;
            out_data_reg.peak_level_bits      <= stats.peak_level;
            out_data_reg.least_level_bits     <= stats.least_level;
            out_data_reg.peak_rate_bps        <= stats.peak_rate;
            out_data_reg.least_rate_bps       <= stats.least_rate;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    vboc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    vboc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    vboc_stats u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (stats_update),
        .level  (level_reg),
        .rate   (rate_reg),
        .cap    (cap),
        .stats  (stats)
    );

endmodule

// ===== rtl/vboc_checker.sv =====
// Port-level checks for the buffer occupancy checker, bound to the top level.
// Depends on vboc_pkg for the beat struct types.
module vboc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input vboc_pkg::out_beat_t out_data,
    input logic                out_valid,
    input logic                out_ready
);
    import vboc_pkg::*;

    // One packet at a time: input closes right after a beat is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still ready after accepting a packet");

    // A waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result beat dropped or changed while stalled");

    // Level lies within its tracked extremes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.least_level_bits <= out_data.level_bits)
                       && (out_data.level_bits <= out_data.peak_level_bits)))
        else $error("level outside its tracked extremes");

    // Rate lies within its tracked extremes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.least_rate_bps <= out_data.packet_rate_bps)
                       && (out_data.packet_rate_bps <= out_data.peak_rate_bps)))
        else $error("rate outside its tracked extremes");

    // An empty buffer is always reported as underflow
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.level_bits == '0)) |-> (out_data.event_code == EV_UNDER))
        else $error("empty buffer not classified as underflow");

endmodule

bind video_buffer_occupancy_checker vboc_checker u_vboc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for video_buffer_occupancy_checker: directed and random packet beats
// checked against a scoreboard that keeps its own leaky-bucket buffer model.
// Depends on rtl/vboc_pkg.sv and rtl/video_buffer_occupancy_checker.sv.
module tb_top;
    import vboc_pkg::*;

    localparam int              QUIET_LIMIT = 2000;
    localparam int              PHASES      = 8;
    localparam int              PHASE_BEATS = 50;
    localparam longint unsigned STAMP_MAX   = (64'd1 << STAMP_WIDTH) - 1;
    localparam longint unsigned FILL_CAP    = 64'd1 << 40;
    localparam longint unsigned COUNT_MAX   = (64'd1 << COUNT_WIDTH) - 1;
    localparam longint unsigned RATE_SAT    = 64'hFFFF_FFFF;
    localparam longint unsigned LEVEL_MASK  = 64'h7FFF_FFFF;

    // Buffer occupancy scoreboard: predicts one result beat per packet beat
    class occupancy_scoreboard;
        longint unsigned size_bytes, fill_bps, tick_rate, dflt_gap;
        longint unsigned level, prev_stamp;
        longint unsigned n_over, n_under, n_near_over, n_near_under;
        longint unsigned level_hi, level_lo, rate_hi, rate_lo;
        out_beat_t       pending_results[$];
        int              errors;

        function new();
            size_bytes   = RST_BUFFER_SIZE;
            fill_bps     = RST_FILL_RATE;
            tick_rate    = RST_TICKS_PER_S;
            dflt_gap     = RST_DEFAULT_GAP;
            level        = 0;
            prev_stamp   = 0;
            n_over       = 0;
            n_under      = 0;
            n_near_over  = 0;
            n_near_under = 0;
            level_hi     = 0;
            level_lo     = LEVEL_MIN_RESET;
            rate_hi      = 0;
            rate_lo      = RATE_MIN_RESET;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_BUFFER_SIZE: size_bytes = data[SIZE_W-1:0];
                REG_FILL_RATE:   fill_bps   = data[FILL_W-1:0];
                REG_TICKS_PER_S: tick_rate  = data[TPS_W-1:0];
                REG_DEFAULT_GAP: dflt_gap   = data[DGAP_W-1:0];
                default: ;
            endcase
        endfunction

        // Fall back to the default gap when there is no earlier stamp or time stalls
        function longint unsigned gap_for(longint unsigned stamp);
            if (prev_stamp == 0 || stamp <= prev_stamp)
                return dflt_gap;
            return stamp - prev_stamp;
        endfunction

        // Channel bits delivered over a gap, split to keep the product in range
        function longint unsigned fill_bits(longint unsigned gap);
            longint unsigned rate_base, whole, part, bits;
            rate_base = (tick_rate != 0) ? tick_rate : 1;
            if (fill_bps == 0)
                return 0;
            whole = gap / rate_base;
            part  = gap % rate_base;
            if (whole >= (64'd1 << 32))
                return FILL_CAP;
            bits = fill_bps * whole + (fill_bps * part) / rate_base;
            return (bits > FILL_CAP) ? FILL_CAP : bits;
        endfunction

        function longint unsigned bumped(longint unsigned n);
            return (n < COUNT_MAX) ? n + 1 : n;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_packet(in_beat_t p);
            longint unsigned stamp, gap, cap, taken, sum, full, rate, rate_base;
            logic [EV_W-1:0] ev;
            out_beat_t       want;
            stamp     = p.stamp_present ? p.stamp_ticks : 0;
            cap       = size_bytes * 8;
            rate_base = (tick_rate != 0) ? tick_rate : 1;
            gap       = gap_for(stamp);
            taken     = p.packet_bytes;
            taken     = taken * 8;

            // fill, drain the packet, clamp to capacity
            sum = level + fill_bits(gap);
            sum = (sum <= taken) ? 0 : sum - taken;
            if (sum > cap)
                sum = cap;
            level = sum & LEVEL_MASK;
            full  = (cap != 0) ? (level * 25600) / cap : 0;

            if (gap == 0)
                rate = RATE_SAT;
            else
                rate = (taken * rate_base) / gap;
            if (rate > RATE_SAT)
                rate = RATE_SAT;

            // classify in priority order
            if (cap == 0 || level == 0)
                ev = EV_UNDER;
            else if (level >= cap)
                ev = EV_OVER;
            else if (level * 10 >= cap * 9)
                ev = EV_NEAR_OVER;
            else if (level * 10 <= cap)
                ev = EV_NEAR_UNDER;
            else
                ev = EV_NORMAL;
            case (ev)
                EV_OVER:       n_over       = bumped(n_over);
                EV_UNDER:      n_under      = bumped(n_under);
                EV_NEAR_OVER:  n_near_over  = bumped(n_near_over);
                EV_NEAR_UNDER: n_near_under = bumped(n_near_under);
                default: ;
            endcase

            if (level > level_hi) level_hi = level;
            if (level < level_lo) level_lo = level;
            if (rate > rate_hi)   rate_hi  = rate;
            if (rate < rate_lo)   rate_lo  = rate;
            prev_stamp = stamp;

            want                      = '0;
            want.level_bits           = level[LEVEL_W-1:0];
            want.fullness_q8          = full[FULL_W-1:0];
            want.event_code           = ev;
            want.packet_rate_bps      = rate[RATE_W-1:0];
            want.overflow_total       = n_over[COUNT_WIDTH-1:0];
            want.underflow_total      = n_under[COUNT_WIDTH-1:0];
            want.near_overflow_total  = n_near_over[COUNT_WIDTH-1:0];
            want.near_underflow_total = n_near_under[COUNT_WIDTH-1:0];
            want.peak_level_bits      = level_hi[LEVEL_W-1:0];
            want.least_level_bits     = level_lo[LEVEL_W-1:0];
            want.peak_rate_bps        = rate_hi[RATE_W-1:0];
            want.least_rate_bps       = rate_lo[RATE_W-1:0];
            pending_results.push_back(want);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with no packet pending: expected none, got %p",
                         $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare("level_bits", want.level_bits, got.level_bits);
            compare("fullness_q8", want.fullness_q8, got.fullness_q8);
            compare("event_code", want.event_code, got.event_code);
            compare("packet_rate_bps", want.packet_rate_bps, got.packet_rate_bps);
            compare("overflow_total", want.overflow_total, got.overflow_total);
            compare("underflow_total", want.underflow_total, got.underflow_total);
            compare("near_overflow_total", want.near_overflow_total, got.near_overflow_total);
            compare("near_underflow_total", want.near_underflow_total,
                    got.near_underflow_total);
            compare("peak_level_bits", want.peak_level_bits, got.peak_level_bits);
            compare("least_level_bits", want.least_level_bits, got.least_level_bits);
            compare("peak_rate_bps", want.peak_rate_bps, got.peak_rate_bps);
            compare("least_rate_bps", want.least_rate_bps, got.least_rate_bps);
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_beat_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_beat_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit                    calm         = 1'b0;
    int                    quiet_cycles = 0;
    occupancy_scoreboard   occupancy;

    video_buffer_occupancy_checker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Stall the result side at random, except in the calm stretch
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 27);
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            occupancy.check_result(out_data);
    end

    // Count cycles with no beat moving on any channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("video_buffer_occupancy_checker test failed");
        $finish;
    end

    function automatic bit sender_idles();
        return !calm && ($urandom_range(99) < 27);
    endfunction

    // Offer one packet beat and hold it until accepted
    task automatic send_packet(input in_beat_t p);
        while (sender_idles())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        occupancy.note_packet(p);
    endtask

    task automatic send_fields(input longint unsigned stamp, input bit present,
                               input int unsigned bytes);
        in_beat_t p;
        p.stamp_ticks   = stamp[STAMP_WIDTH-1:0];
        p.stamp_present = present;
        p.packet_bytes  = bytes[BYTES_W-1:0];
        send_packet(p);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] index, input longint unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        occupancy.write_reg(index, value[CFG_DATA_W-1:0]);
    endtask

    task automatic load_config(input longint unsigned size_v, input longint unsigned fill_v,
                               input longint unsigned tps_v, input longint unsigned gap_v);
        set_register(REG_BUFFER_SIZE, size_v);
        set_register(REG_FILL_RATE, fill_v);
        set_register(REG_TICKS_PER_S, tps_v);
        set_register(REG_DEFAULT_GAP, gap_v);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (occupancy.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_config(input int phase);
        case (phase)
            0: load_config(268435455, 1000000000, 1000000, 1000000);
            1: load_config(1, 0, 1, 1);
            default:
                load_config(($urandom_range(3) == 0) ? $urandom_range(1, 268435455)
                                                      : $urandom_range(1, 100000),
                            ($urandom_range(1) == 0) ? $urandom_range(0, 1000000000)
                                                      : $urandom_range(100000, 50000000),
                            ($urandom_range(1) == 0) ? 90000 : $urandom_range(1, 1000000),
                            $urandom_range(1, 1000000));
        endcase
    endtask

    // Mostly well-formed packets sized to land on a random level; some noise
    function automatic in_beat_t random_packet();
        in_beat_t        p;
        longint unsigned cap, stamp, reach, goal, take, step;
        int unsigned     roll, span;
        roll = $urandom_range(99);
        cap  = occupancy.size_bytes * 8;
        p    = '0;
        if (roll < 10) begin
            stamp           = {$urandom, $urandom};
            p.stamp_ticks   = stamp[STAMP_WIDTH-1:0];
            p.stamp_present = $urandom_range(1);
            p.packet_bytes  = $urandom_range(24'hFFFFFF);
        end
        else if (roll < 20) begin
            // missing, repeated or backward stamp
            case ($urandom_range(2))
                0: begin
                    stamp           = {$urandom, $urandom};
                    p.stamp_present = 1'b0;
                end
                1: begin
                    stamp           = occupancy.prev_stamp;
                    p.stamp_present = 1'b1;
                end
                default: begin
                    stamp           = occupancy.prev_stamp >> $urandom_range(1, 8);
                    p.stamp_present = 1'b1;
                end
            endcase
            p.stamp_ticks  = stamp[STAMP_WIDTH-1:0];
            p.packet_bytes = $urandom_range(65535);
        end
        else begin
            step            = occupancy.dflt_gap;
            step            = step / 2 + $urandom_range(int'(step)) + 1;
            stamp           = (occupancy.prev_stamp + step) & STAMP_MAX;
            p.stamp_ticks   = stamp[STAMP_WIDTH-1:0];
            p.stamp_present = 1'b1;
            reach = occupancy.level + occupancy.fill_bits(occupancy.gap_for(stamp));
            span  = cap + cap / 10;
            goal  = ($urandom_range(6) == 0) ? 0 : $urandom_range(span);
            take  = (reach > goal) ? reach - goal : 0;
            if (goal == 0)
                take = take + $urandom_range(4096);
            take = (take + 7) / 8;
            p.packet_bytes = (take > 24'hFFFFFF) ? 24'hFFFFFF : take[BYTES_W-1:0];
        end
        return p;
    endfunction

    initial
    begin
        occupancy = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: stamp handling and the extremes of the fields
        send_fields(64'h1_2345_6789, 1'b0, 1000);
        send_fields(0, 1'b1, 0);
        send_fields(3000, 1'b1, 20000);
        send_fields(6000, 1'b1, 20833);
        send_fields(6000, 1'b1, 0);
        send_fields(5000, 1'b1, 0);
        send_fields(STAMP_MAX, 1'b1, 0);
        send_fields(STAMP_MAX, 1'b1, 177083);
        send_fields(1, 1'b1, 24'hFFFFFF);
        send_fields(90001, 1'b1, 2);
        send_fields(90002, 1'b1, 24'hFFFFFF);
        drain_results();

        // One bit per tick: walk the level onto each class boundary exactly
        load_config(100, 1, 1, 1);
        send_fields(100, 1'b1, 24'hFFFFFF);
        send_fields(820, 1'b1, 0);
        send_fields(900, 1'b1, 0);
        send_fields(908, 1'b1, 91);
        send_fields(909, 1'b1, 0);
        send_fields(1000, 1'b1, 0);
        send_fields(1547, 1'b1, 0);
        drain_results();

        // Zero capacity, zero tick rate, zero default gap
        load_config(0, 1000000000, 0, 0);
        send_fields(5, 1'b1, 10);
        send_fields(10, 1'b1, 10);
        send_fields(STAMP_MAX, 1'b1, 0);
        send_fields(STAMP_MAX, 1'b0, 1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            random_config(phase);
            calm = (phase == 4);
            for (int n = 0; n < PHASE_BEATS; n++)
                send_packet(random_packet());
        end
        calm = 1'b0;

        drain_results();
        repeat (120) @(posedge clk);
        if (occupancy.errors == 0 && occupancy.pending() == 0)
            $display("video_buffer_occupancy_checker test passed");
        else
            $display("video_buffer_occupancy_checker test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vboc_pkg.sv
rtl/vboc_mul.sv
rtl/vboc_div.sv
rtl/vboc_stats.sv
rtl/video_buffer_occupancy_checker.sv
rtl/vboc_checker.sv
test/tb_top.sv
